[rtl/line_follower_pid_drive_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the line follower PID drive block
// Shared property wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PID_DRIVE_TOP_MACROS_SVH
`define LINE_FOLLOWER_PID_DRIVE_TOP_MACROS_SVH

// Same-cycle implication.
`define LFPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lfpd_pkg.sv]
// ---------------------------------------------------------------------------
// Line follower PID drive package
// Shared types, register indexes and constants of the steering pipeline.
// ---------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_PWM_TOP     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_LEFT  = 2'd2
  } side_t;

  localparam logic [15:0] GAIN_P_RST      = 16'd5120;
  localparam logic [15:0] GAIN_I_RST      = 16'd0;
  localparam logic [15:0] GAIN_D_RST      = 16'd0;
  localparam logic [9:0]  BASE_SPEED_RST  = 10'd600;
  localparam logic [9:0]  DRIVE_LIMIT_RST = 10'd600;
  localparam logic [9:0]  PWM_TOP_RST     = 10'd1000;

  localparam logic [4:0]         SENSORS_DARK = 5'h1F;
  localparam logic signed [5:0]  WEIGHT_OUTER = 6'sd5;
  localparam logic signed [5:0]  WEIGHT_INNER = 6'sd2;
  localparam logic signed [5:0]  ERR_EDGE     = 6'sd16;
  localparam logic signed [23:0] SUM_MAX      = 24'sh7FFFFF;
  localparam logic signed [23:0] SUM_MIN      = -24'sh800000;
  localparam logic signed [41:0] ROUND_BIAS   = 42'sd255;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [9:0]  base_speed;
    logic [9:0]  drive_limit;
    logic [9:0]  pwm_top;
  } cfg_t;

  typedef struct packed {
    logic signed [5:0]  err;
    logic signed [5:0]  p;
    logic signed [23:0] sum;
    logic signed [6:0]  d;
  } front_t;

  typedef struct packed {
    logic signed [5:0]  err;
    logic signed [22:0] prod_p;
    logic signed [40:0] prod_i;
    logic signed [23:0] prod_d;
  } prod_t;

endpackage

[rtl/lfpd_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Configuration register file
// Holds the PID gains, base speed, drive limit and PWM top.
// ---------------------------------------------------------------------------
module lfpd_cfg_regs
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= GAIN_P_RST;
      cfg.gain_i      <= GAIN_I_RST;
      cfg.gain_d      <= GAIN_D_RST;
      cfg.base_speed  <= BASE_SPEED_RST;
      cfg.drive_limit <= DRIVE_LIMIT_RST;
      cfg.pwm_top     <= PWM_TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:      cfg.gain_p      <= cfg_data;
        REG_GAIN_I:      cfg.gain_i      <= cfg_data;
        REG_GAIN_D:      cfg.gain_d      <= cfg_data;
        REG_BASE_SPEED:  cfg.base_speed  <= cfg_data[9:0];
        REG_DRIVE_LIMIT: cfg.drive_limit <= cfg_data[9:0];
        REG_PWM_TOP:     cfg.pwm_top     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lfpd_front.sv]
// ---------------------------------------------------------------------------
// Sensor decode and controller state
// Forms the line error and updates side memory, integral and last input.
// ---------------------------------------------------------------------------
`include "line_follower_pid_drive_top_macros.svh"

module lfpd_front
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [4:0] sensor_bits,
  output logic       dn_valid,
  input  logic       dn_ready,
  output front_t     dn_data
);

  side_t              last_side;
  side_t              last_side_next;
  logic signed [23:0] error_sum;
  logic signed [5:0]  previous_error;
  logic [4:0]         seen;
  logic signed [5:0]  weight;
  logic [2:0]         count;
  logic signed [5:0]  err_raw;
  front_t             front_next;
  logic signed [24:0] sum_wide;
  logic               accept;

  assign up_ready = !dn_valid || dn_ready;
  assign accept   = up_valid && up_ready;

  always_comb begin
    seen   = ~sensor_bits;
    weight = (seen[4] ? WEIGHT_OUTER : 6'sd0) + (seen[3] ? WEIGHT_INNER : 6'sd0)
           - (seen[1] ? WEIGHT_INNER : 6'sd0) - (seen[0] ? WEIGHT_OUTER : 6'sd0);
    count  = 3'(seen[4]) + 3'(seen[3]) + 3'(seen[1]) + 3'(seen[0]);
    err_raw = 6'(weight * $signed({3'b000, count}));

    last_side_next = last_side;
    if (seen != 5'd0) begin
      priority if (seen[0]) begin
        last_side_next = SIDE_LEFT;
      end else if (seen[3] || seen[2] || seen[1]) begin
        last_side_next = SIDE_NONE;
      end else if (seen[4]) begin
        last_side_next = SIDE_RIGHT;
      end else begin
        last_side_next = SIDE_NONE;
      end
    end

    front_next.err = err_raw;
    if (err_raw == 6'sd0) begin
      unique case (last_side_next)
        SIDE_RIGHT: front_next.err = -ERR_EDGE;
        SIDE_LEFT:  front_next.err = ERR_EDGE;
        default:    front_next.err = 6'sd0;
      endcase
    end

    front_next.p = -front_next.err;
    sum_wide = 25'(error_sum) + 25'(front_next.p);
    if (sum_wide > 25'(SUM_MAX)) begin
      front_next.sum = SUM_MAX;
    end else if (sum_wide < 25'(SUM_MIN)) begin
      front_next.sum = SUM_MIN;
    end else begin
      front_next.sum = sum_wide[23:0];
    end
    front_next.d = 7'(previous_error) - 7'(front_next.p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid       <= 1'b0;
      last_side      <= SIDE_NONE;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (up_ready) begin
        dn_valid <= up_valid;
      end
      if (accept) begin
        last_side      <= last_side_next;
        error_sum      <= front_next.sum;
        previous_error <= front_next.p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dn_data <= front_next;
    end
  end

  `LFPD_ASSERT_NXT(a_side_kept_when_dark, accept && (sensor_bits == SENSORS_DARK),
    last_side == $past(last_side), "side memory changed on a dark sample")

endmodule

[rtl/lfpd_mult.sv]
// ---------------------------------------------------------------------------
// PID gain multipliers
// Registers the three Q8.8 gain products of one control tick.
// ---------------------------------------------------------------------------
module lfpd_mult
  import lfpd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_ready,
  input  front_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output prod_t  dn_data
);

  prod_t             prod_next;
  logic signed [16:0] gp;
  logic signed [16:0] gi;
  logic signed [16:0] gd;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    gp = $signed({1'b0, cfg.gain_p});
    gi = $signed({1'b0, cfg.gain_i});
    gd = $signed({1'b0, cfg.gain_d});
    prod_next.err    = up_data.err;
    prod_next.prod_p = 23'(gp) * 23'(up_data.p);
    prod_next.prod_i = 41'(gi) * 41'(up_data.sum);
    prod_next.prod_d = 24'(gd) * 24'(up_data.d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= prod_next;
    end
  end

endmodule

[rtl/lfpd_drive_out.sv]
// ---------------------------------------------------------------------------
// Drive clamp and motor compare stage
// Sums the products, scales toward zero, clamps and saturates compares.
// ---------------------------------------------------------------------------
`include "line_follower_pid_drive_top_macros.svh"

module lfpd_drive_out
  import lfpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  prod_t              up_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [5:0]  line_error,
  output logic signed [10:0] drive,
  output logic [9:0]         left_compare,
  output logic [9:0]         right_compare
);

  logic signed [41:0] acc;
  logic signed [41:0] acc_adj;
  logic signed [33:0] q;
  logic signed [33:0] lim_wide;
  logic signed [10:0] lim_s;
  logic signed [11:0] top_s;
  logic signed [11:0] lc_raw;
  logic signed [11:0] rc_raw;
  logic signed [10:0] drive_next;
  logic [9:0]         left_compare_next;
  logic [9:0]         right_compare_next;
  logic               accept;

  assign up_ready = !out_valid || !out_stall;
  assign accept   = up_valid && up_ready;
  assign lim_s    = $signed({1'b0, cfg.drive_limit});

  always_comb begin
    acc      = 42'($signed(up_data.prod_p)) + 42'($signed(up_data.prod_i))
             + 42'($signed(up_data.prod_d));
    acc_adj  = acc + (acc[41] ? ROUND_BIAS : 42'sd0);
    q        = $signed(acc_adj[41:8]);
    lim_wide = $signed({24'd0, cfg.drive_limit});
    if (q > lim_wide) begin
      drive_next = lim_s;
    end else if (q < -lim_wide) begin
      drive_next = -lim_s;
    end else begin
      drive_next = q[10:0];
    end

    top_s  = $signed({2'b00, cfg.pwm_top});
    lc_raw = $signed({2'b00, cfg.base_speed}) - 12'(drive_next);
    rc_raw = $signed({2'b00, cfg.base_speed}) + 12'(drive_next);

    if (lc_raw < 12'sd0) begin
      left_compare_next = 10'd0;
    end else if (lc_raw > top_s) begin
      left_compare_next = cfg.pwm_top;
    end else begin
      left_compare_next = lc_raw[9:0];
    end

    if (rc_raw < 12'sd0) begin
      right_compare_next = 10'd0;
    end else if (rc_raw > top_s) begin
      right_compare_next = cfg.pwm_top;
    end else begin
      right_compare_next = rc_raw[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      line_error    <= '0;
      drive         <= '0;
      left_compare  <= '0;
      right_compare <= '0;
    end else begin
      if (up_ready) begin
        out_valid <= up_valid;
      end
      if (accept) begin
        line_error    <= up_data.err;
        drive         <= drive_next;
        left_compare  <= left_compare_next;
        right_compare <= right_compare_next;
      end
    end
  end

  `LFPD_ASSERT_IMP(a_drive_within_limit, out_valid,
    (drive <= lim_s) && (drive >= -lim_s), "drive exceeds the configured limit")
  `LFPD_ASSERT_IMP(a_left_within_top, out_valid,
    left_compare <= cfg.pwm_top, "left compare above PWM top")
  `LFPD_ASSERT_IMP(a_right_within_top, out_valid,
    right_compare <= cfg.pwm_top, "right compare above PWM top")

endmodule

[rtl/line_follower_pid_drive_top.sv]
// ---------------------------------------------------------------------------
// Line follower PID drive
// Line sensor decode, PID steering and motor compare generation.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one word per control tick: five active-low line
// sensor bits. Each accepted word yields exactly one result word on the output
// channel with the line error, the clamped PID drive and the two motor compare
// values. The configuration channel writes gains and limits by index; the user
// must write them only while the block is idle, as the block does not enforce
// it. It is always ready, and writes to unused indexes are dropped. An accepted
// word passes through three stages, the decode, multiply and clamp registers,
// to out_valid, and a new word is accepted every cycle while out_stall is low.
// Reset clears the side memory, the integral and the previous error, empties
// the pipeline and loads the register defaults. When the receiver holds
// out_stall, the result word stays put and the earlier stages keep filling
// until every stage holds a word; only then does in_stall rise.
// ---------------------------------------------------------------------------
module line_follower_pid_drive_top
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            sensor_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [5:0]     line_error,
  output logic signed [10:0]    drive,
  output logic [9:0]            left_compare,
  output logic [9:0]            right_compare,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   in_ready;
  logic   front_valid;
  logic   front_ready;
  front_t front_data;
  logic   prod_valid;
  logic   prod_ready;
  prod_t  prod_data;

  assign in_stall = !in_ready;

  lfpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .sensor_bits (sensor_bits),
    .dn_valid    (front_valid),
    .dn_ready    (front_ready),
    .dn_data     (front_data)
  );

  lfpd_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  lfpd_drive_out u_out (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .up_valid      (prod_valid),
    .up_ready      (prod_ready),
    .up_data       (prod_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_error    (line_error),
    .drive         (drive),
    .left_compare  (left_compare),
    .right_compare (right_compare)
  );

endmodule

[dv/line_follower_pid_drive_top_test.sv]
// ---------------------------------------------------------------------------
// Line follower PID drive testbench
// Drives sensor words through the steering block under several register
// settings, predicts every result word from its own model of the sensor
// decode, side memory, PID and compare saturation, and checks each result
// in order. Both channels idle and stall at random. A run of dark words
// with no idling walks the integral steadily downward.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follower_pid_drive_top_test;
  import lfpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;
  localparam logic [4:0] LEFT_ONLY  = 5'h1E;
  localparam logic [4:0] RIGHT_ONLY = 5'h0F;
  localparam int SATURATION_WORDS = 40;

  typedef struct {
    logic signed [5:0]  err;
    logic signed [10:0] drv;
    logic [9:0]         lc;
    logic [9:0]         rc;
  } steer_word_t;

  class pid_scoreboard;
    cfg_t               regs;
    side_t              side_mem;
    logic signed [23:0] integral;
    logic signed [5:0]  last_p;
    steer_word_t        expected_q[$];
    int                 mismatches;

    function new();
      regs = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
               base_speed: BASE_SPEED_RST, drive_limit: DRIVE_LIMIT_RST,
               pwm_top: PWM_TOP_RST};
      side_mem = SIDE_NONE;
      integral = '0;
      last_p = '0;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:      regs.gain_p = data;
        REG_GAIN_I:      regs.gain_i = data;
        REG_GAIN_D:      regs.gain_d = data;
        REG_BASE_SPEED:  regs.base_speed = data[9:0];
        REG_DRIVE_LIMIT: regs.drive_limit = data[9:0];
        REG_PWM_TOP:     regs.pwm_top = data[9:0];
        default: ;
      endcase
    endfunction

    function logic [9:0] clamp_compare(int v, int top);
      if (v < 0) return '0;
      if (v > top) return top[9:0];
      return v[9:0];
    endfunction

    function void note_input(logic [4:0] bits);
      logic [4:0]  seen;
      int          sl, sml, sc, smr, sr, err, p, d, lim, top, drv;
      longint      sum, acc, q;
      steer_word_t w;
      seen = ~bits;
      sl = seen[0];
      sml = seen[1];
      sc = seen[2];
      smr = seen[3];
      sr = seen[4];
      if (seen != '0) begin
        side_mem = sr ? SIDE_RIGHT : SIDE_NONE;
        if (smr || sc || sml) side_mem = SIDE_NONE;
        if (sl) side_mem = SIDE_LEFT;
      end
      err = (sr * 5 + smr * 2 - sml * 2 - sl * 5) * (sr + smr + sml + sl);
      if (err == 0) begin
        if (side_mem == SIDE_RIGHT) err = -16;
        else if (side_mem == SIDE_LEFT) err = 16;
      end
      p = -err;
      sum = longint'(integral) + p;
      if (sum > 8388607) sum = 8388607;
      if (sum < -8388608) sum = -8388608;
      integral = sum[23:0];
      d = int'(last_p) - p;
      last_p = p[5:0];
      acc = longint'(regs.gain_p) * p + longint'(regs.gain_i) * sum
            + longint'(regs.gain_d) * d;
      q = acc / 256;
      lim = int'(regs.drive_limit);
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      drv = int'(q);
      top = int'(regs.pwm_top);
      w.err = err[5:0];
      w.drv = drv[10:0];
      w.lc = clamp_compare(int'(regs.base_speed) - drv, top);
      w.rc = clamp_compare(int'(regs.base_speed) + drv, top);
      expected_q.push_back(w);
    endfunction

    task check_result(logic signed [5:0] err, logic signed [10:0] drv,
                      logic [9:0] lc, logic [9:0] rc);
      steer_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing expected, line_error %0d drive %0d",
                         err, drv));
        return;
      end
      w = expected_q.pop_front();
      if (err !== w.err) report($sformatf("line_error got %0d want %0d", err, w.err));
      if (drv !== w.drv) report($sformatf("drive got %0d want %0d", drv, w.drv));
      if (lc !== w.lc) report($sformatf("left_compare got %0d want %0d", lc, w.lc));
      if (rc !== w.rc) report($sformatf("right_compare got %0d want %0d", rc, w.rc));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [4:0]            sensor_bits = SENSORS_DARK;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [5:0]     line_error;
  logic signed [10:0]    drive;
  logic [9:0]            left_compare;
  logic [9:0]            right_compare;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_scoreboard sb = new();
  bit            steady = 1'b0;
  int unsigned   cycle_count = 0;

  logic [4:0] corner_words [21] = '{
    5'h1F, 5'h00, 5'h1F, 5'h0F, 5'h1F, 5'h1B, 5'h1F, 5'h1E, 5'h1F, 5'h1D, 5'h17,
    5'h07, 5'h1C, 5'h03, 5'h11, 5'h0E, 5'h05, 5'h14, 5'h0F, 5'h1B, 5'h1F
  };

  line_follower_pid_drive_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sensor_bits   (sensor_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_error    (line_error),
    .drive         (drive),
    .left_compare  (left_compare),
    .right_compare (right_compare),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(sensor_bits);
      if (out_valid && !out_stall) begin
        sb.check_result(line_error, drive, left_compare, right_compare);
      end
    end
  end

  initial begin : result_sink
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [4:0] line_pattern();
    logic [4:0] mask;
    case ($urandom_range(0, 9))
      0, 1, 2: return 5'($urandom_range(0, 31));
      3, 4, 5: begin
        mask = 5'b00001 << $urandom_range(0, 4);
        if ($urandom_range(0, 1)) mask = mask | (mask << 1);
        return ~mask;
      end
      6, 7: return SENSORS_DARK;
      8: return '0;
      default: return $urandom_range(0, 1) ? LEFT_ONLY : RIGHT_ONLY;
    endcase
  endfunction

  task automatic send_word(logic [4:0] bits);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_all(int gp, int gi, int gd, int bs, int dl, int pt);
    write_cfg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_cfg(REG_GAIN_I, CFG_DATA_W'(gi));
    write_cfg(REG_GAIN_D, CFG_DATA_W'(gd));
    write_cfg(REG_BASE_SPEED, CFG_DATA_W'(bs));
    write_cfg(REG_DRIVE_LIMIT, CFG_DATA_W'(dl));
    write_cfg(REG_PWM_TOP, CFG_DATA_W'(pt));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if (!steady && $urandom_range(0, 63) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      send_word(line_pattern());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_words[i]) send_word(corner_words[i]);
    wait_idle();

    set_all(256, 1, 128, 512, 1023, 1023);
    run_random(200);
    wait_idle();

    set_all(65535, 65535, 65535, 1023, 1023, 1023);
    run_random(150);
    wait_idle();

    set_all(0, 0, 0, 0, 0, 1);
    write_cfg(IDX_UNUSED_LO, CFG_DATA_W'($urandom_range(0, 65535)));
    write_cfg(IDX_UNUSED_HI, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    @(posedge clk);
    run_random(150);
    wait_idle();

    steady = 1'b1;
    set_all(3000, 0, 20000, 1023, 300, 500);
    run_random(150);
    wait_idle();
    steady = 1'b0;

    set_all(1000, 2, 500, 300, 1023, 0);
    run_random(100);
    wait_idle();

    repeat (6) begin
      steady = ($urandom_range(0, 3) == 0);
      set_all($urandom_range(0, 65535),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4),
              $urandom_range(0, 65535), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(1, 1023));
      run_random(180);
      wait_idle();
    end

    // With the left edge remembered, every dark word adds -16 to the integral,
    // so a back-to-back run of them drives it steadily downward.
    steady = 1'b1;
    set_all(0, 1, 0, 512, 1023, 1023);
    send_word(LEFT_ONLY);
    repeat (SATURATION_WORDS) send_word(SENSORS_DARK);
    steady = 1'b0;
    run_random(30);
    wait_idle();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lfpd_pkg.sv
rtl/lfpd_cfg_regs.sv
rtl/lfpd_front.sv
rtl/lfpd_mult.sv
rtl/lfpd_drive_out.sv
rtl/line_follower_pid_drive_top.sv
dv/line_follower_pid_drive_top_test.sv
